/* sv/ccfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ccfr_pkg: shared types and helpers for the COBS/CRC-16 frame receiver
// Frame status codes, result word layout and the byte-wide CRC update.
// ---------------------------------------------------------------------------
package ccfr_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_CRC      = 3'd1,
		ST_SHORT    = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       frame_end;
		status_t    frame_status;
	} result_t;

	localparam logic [7:0]  DELIM     = 8'h00;
	localparam logic [7:0]  CODE_MAX  = 8'hFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/ccfr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ccfr_if: valid/ready channels of the frame receiver
// Link byte channel in, decoded word/status channel out.
// ---------------------------------------------------------------------------
interface ccfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;

	modport source (output valid, output raw_byte, input ready);
	modport sink   (input valid, input raw_byte, output ready);
endinterface

interface ccfr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       frame_end;
	logic [2:0] frame_status;

	modport source (output valid, output payload_byte, output frame_end,
		output frame_status, input ready);
	modport sink   (input valid, input payload_byte, input frame_end,
		input frame_status, output ready);
endinterface
`default_nettype wire

/* sv/ccfr_frame_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ccfr_frame_decoder: per-byte COBS decode, CRC hold-back and frame status
// Updates frame state once per step and offers at most one result word.
// ---------------------------------------------------------------------------
module ccfr_frame_decoder #(
	parameter int MAX_PAYLOAD = 256,
	parameter int MIN_HEADER  = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        raw_byte,
	output logic                   res_valid,
	output ccfr_pkg::result_t      res
);

	localparam int RAW_CAP   = 2 * MAX_PAYLOAD + 4;
	localparam int DEC_CAP   = MAX_PAYLOAD + 2;
	localparam int SHORT_MIN = MIN_HEADER + 2;
	localparam int RCW       = $clog2(RAW_CAP + 1);
	// counter must also hold the short-frame threshold
	localparam int DCW       = $clog2(((DEC_CAP > SHORT_MIN) ? DEC_CAP : SHORT_MIN) + 1);

	logic [RCW-1:0] raw_count_q,   raw_count_d;
	logic [DCW-1:0] dec_count_q,   dec_count_d;
	logic [7:0]     group_left_q,  group_left_d;
	logic           zero_pend_q,   zero_pend_d;
	logic           overflow_q,    overflow_d;
	logic [15:0]    crc_q,         crc_d;
	logic [7:0]     hold0_q,       hold0_d;
	logic [7:0]     hold1_q,       hold1_d;

	logic           push;
	logic [7:0]     push_byte;
	logic [15:0]    rx_crc;

	assign rx_crc = {hold1_q, hold0_q};

	always_comb begin
		raw_count_d  = raw_count_q;
		dec_count_d  = dec_count_q;
		group_left_d = group_left_q;
		zero_pend_d  = zero_pend_q;
		overflow_d   = overflow_q;
		crc_d        = crc_q;
		hold0_d      = hold0_q;
		hold1_d      = hold1_q;
		push         = 1'b0;
		push_byte    = ccfr_pkg::DELIM;
		res_valid    = 1'b0;
		res          = '{payload_byte: 8'h00, frame_end: 1'b0,
			frame_status: ccfr_pkg::ST_OK};

		if (raw_byte == ccfr_pkg::DELIM) begin
			if (raw_count_q != '0) begin
				res_valid     = 1'b1;
				res.frame_end = 1'b1;
				if (overflow_q) begin
					res.frame_status = ccfr_pkg::ST_OVERFLOW;
				end else if (group_left_q != 8'h00) begin
					res.frame_status = ccfr_pkg::ST_TRUNC;
				end else if (dec_count_q < DCW'(SHORT_MIN)) begin
					res.frame_status = ccfr_pkg::ST_SHORT;
				end else if (rx_crc == crc_q) begin
					res.frame_status = ccfr_pkg::ST_OK;
				end else begin
					res.frame_status = ccfr_pkg::ST_CRC;
				end
			end
			raw_count_d  = '0;
			dec_count_d  = '0;
			group_left_d = 8'h00;
			zero_pend_d  = 1'b0;
			overflow_d   = 1'b0;
			crc_d        = ccfr_pkg::CRC_INIT;
			hold0_d      = 8'h00;
			hold1_d      = 8'h00;
		end else if (!overflow_q) begin
			if (raw_count_q >= RCW'(RAW_CAP)) begin
				overflow_d = 1'b1;
			end else begin
				raw_count_d = raw_count_q + RCW'(1);
				if (group_left_q == 8'h00) begin
					// code byte: flush the zero owed by the last short group
					push         = zero_pend_q;
					push_byte    = ccfr_pkg::DELIM;
					group_left_d = raw_byte - 8'd1;
					zero_pend_d  = (raw_byte != ccfr_pkg::CODE_MAX);
				end else begin
					push         = 1'b1;
					push_byte    = raw_byte;
					group_left_d = group_left_q - 8'd1;
				end
			end

			if (push) begin
				if (dec_count_q >= DCW'(DEC_CAP)) begin
					overflow_d = 1'b1;
				end else begin
					dec_count_d = dec_count_q + DCW'(1);
					if (dec_count_q >= DCW'(2)) begin
						res_valid        = 1'b1;
						res.payload_byte = hold0_q;
						crc_d            = ccfr_pkg::crc_byte(crc_q, hold0_q);
						hold0_d          = hold1_q;
						hold1_d          = push_byte;
					end else if (dec_count_q[0]) begin
						hold1_d = push_byte;
					end else begin
						hold0_d = push_byte;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_count_q  <= '0;
			dec_count_q  <= '0;
			group_left_q <= 8'h00;
			zero_pend_q  <= 1'b0;
			overflow_q   <= 1'b0;
			crc_q        <= ccfr_pkg::CRC_INIT;
			hold0_q      <= 8'h00;
			hold1_q      <= 8'h00;
		end else if (step) begin
			raw_count_q  <= raw_count_d;
			dec_count_q  <= dec_count_d;
			group_left_q <= group_left_d;
			zero_pend_q  <= zero_pend_d;
			overflow_q   <= overflow_d;
			crc_q        <= crc_d;
			hold0_q      <= hold0_d;
			hold1_q      <= hold1_d;
		end
	end

endmodule
`default_nettype wire

/* sv/cobs_crc16_frame_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cobs_crc16_frame_receiver: streaming COBS decoder with CRC-16 frame check
// Decodes delimited COBS frames byte by byte, streams payload words and ends
// each non-empty frame with one status word.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                  | word
//  link    | in  | raw_byte[7:0]                            | one link byte, 0 = delimiter
//  frame   | out | payload_byte[7:0], frame_end, status[2:0] | payload or end-of-frame
//
//  One link byte per cycle sustained while frame is ready; link to frame
//  passes the input register, then the result register after the decode logic.
//  A byte that produces no word (code bytes, held-back CRC bytes, discards)
//  just passes through. Stalls on frame back up into link only when both
//  registers are full. arst_n clears all frame state and empties both stages.
// ---------------------------------------------------------------------------
module cobs_crc16_frame_receiver #(
	parameter int MAX_PAYLOAD = 256,
	parameter int MIN_HEADER  = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ccfr_byte_if.sink      link,
	ccfr_result_if.source  frame
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result stage
	logic              out_valid_q;
	ccfr_pkg::result_t out_q;

	logic              advance;   // result register can take a new word
	logic              step;      // stage-1 byte is processed this cycle
	logic              res_valid;
	ccfr_pkg::result_t res;

	assign advance    = !out_valid_q || frame.ready;
	assign step       = valid_s1 && advance;
	assign link.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (link.ready) begin
			valid_s1 <= link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link.valid && link.ready) begin
			byte_s1 <= link.raw_byte;
		end
	end

	// COBS decode, hold-back of the trailing CRC and status at the delimiter
	ccfr_frame_decoder #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.MIN_HEADER  (MIN_HEADER)
	) u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.raw_byte  (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register: new word only when the previous one has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.payload_byte = out_q.payload_byte;
	assign frame.frame_end    = out_q.frame_end;
	assign frame.frame_status = out_q.frame_status;

endmodule
`default_nettype wire
